>>> sv/fixed_block_pool_allocator_macros.svh
// Assertion helpers for the pool allocator checker.
// Each helper expects signals named clk and rst_n in the using scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FBPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa: same-cycle check failed");

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa: next-cycle check failed");

`endif

>>> sv/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    // wide enough to hold 0..MAX_BLOCKS
    localparam int COUNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] POOL_BASE_RST   = 32'd0;
    localparam logic [15:0] BLOCK_SIZE_RST  = 16'd64;
    localparam logic [6:0]  BLOCK_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_SIZE     = 2'd2,
        ST_NOT_LIVE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SEARCH
    } state_t;

    // broadcast to every live-list cell
    typedef struct packed {
        logic               start;
        logic               step;
        logic               append;
        logic               remove;
        logic [COUNT_W-1:0] live_count;
    } live_ctl_t;

    // reported by every live-list cell
    typedef struct packed {
        logic tok;
        logic hit;
        logic stop;
    } live_stat_t;

    // broadcast to every free-stack cell
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

>>> sv/fbpa_if.sv
`timescale 1ns / 1ps

interface fbpa_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] request_size;
    logic [31:0] free_address;

    modport source (output valid, kind, request_size, free_address, input ready);
    modport sink   (input valid, kind, request_size, free_address, output ready);
endinterface

interface fbpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [1:0]  status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

interface fbpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

>>> sv/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Channel | Dir | Word                                   | Accepted when
// --------+-----+----------------------------------------+----------------------
// req     | in  | kind, request_size, free_address       | req.valid & req.ready
// rsp     | out | block_address, status                  | rsp.valid & rsp.ready
// cfg     | in  | index, wdata (pool_base/size/count)    | cfg.valid & cfg.ready
//
// One request in flight. Allocate: accept, then grant.
// Free: accept, then the search token walks one live cell per cycle while the
// result register is free, until a match or the end of the live list.
// Reset clears the counts and config; list contents need no clearing pass.
// A word waiting in the result register stalls the grant or the search;
// the next request is taken as soon as the previous one has been answered.
module fixed_block_pool_allocator (
    input  logic        clk,
    input  logic        rst_n,
    fbpa_req_if.sink    req,
    fbpa_rsp_if.source  rsp,
    fbpa_cfg_if.sink    cfg
);
    import fbpa_pkg::*;

    localparam int LAST = MAX_BLOCKS - 1;

    // control
    state_t state_reg;
    state_t state_next;

    // request latched at accept
    logic [15:0] size_reg;
    logic [31:0] key_reg;

    // config registers
    logic [31:0] pool_base_reg;
    logic [15:0] block_size_reg;
    logic [6:0]  block_count_reg;

    // counts
    logic [COUNT_W-1:0] free_count_reg;
    logic [COUNT_W-1:0] free_count_next;
    logic [COUNT_W-1:0] bump_reg;
    logic [COUNT_W-1:0] bump_next;
    logic [COUNT_W-1:0] live_count_reg;
    logic [COUNT_W-1:0] live_count_next;

    // result register
    logic        rsp_valid_reg;
    logic [31:0] rsp_addr_reg;
    status_t     rsp_status_reg;
    logic        rsp_load;
    logic [31:0] rsp_addr_next;
    status_t     rsp_status_next;

    // cell row wiring
    live_ctl_t   live_ctl;
    stack_ctl_t  stack_ctl;
    logic [31:0] append_addr;
    logic [31:0] live_data  [MAX_BLOCKS];
    live_stat_t  live_stat  [MAX_BLOCKS];
    logic [31:0] stack_data [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] hit_vec;
    logic [MAX_BLOCKS-1:0] stop_vec;

    logic req_accept;
    logic cfg_write;
    logic out_free;
    logic hit_any;
    logic miss_any;
    logic live_full;
    logic stack_full;
    logic stack_empty;
    logic bump_ok;
    logic [COUNT_W+15:0] bump_offset;
    logic [31:0]         bump_addr;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && cfg.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.block_address = rsp_addr_reg;
    assign rsp.status        = rsp_status_reg;

    // ------------------------------------------------------------------
    // Config writes; indexes past the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= POOL_BASE_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_POOL_BASE:   pool_base_reg   <= cfg.wdata;
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg.wdata[15:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg.wdata[6:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bump address and capacity checks
    // ------------------------------------------------------------------
    assign bump_offset = bump_reg * block_size_reg;
    assign bump_addr   = pool_base_reg + 32'(bump_offset);
    // a block_count above capacity acts as MAX_BLOCKS
    assign bump_ok     = (32'(bump_reg) < 32'(block_count_reg))
                      && (32'(bump_reg) < 32'(MAX_BLOCKS));
    assign live_full   = (32'(live_count_reg) >= 32'(MAX_BLOCKS));
    assign stack_full  = (32'(free_count_reg) >= 32'(MAX_BLOCKS));
    assign stack_empty = (free_count_reg == '0);

    // ------------------------------------------------------------------
    // Live list: one cell per slot, oldest entry in slot 0.
    // A free drops a token into slot 0; it moves one slot per cycle while the result register is free.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_live
        logic [31:0] nbr_data;
        logic        tok_prev;

        if (g == LAST)
        begin : g_end
            assign nbr_data = '0;
        end
        else
        begin : g_mid
            assign nbr_data = live_data[g+1];
        end

        if (g == 0)
        begin : g_head
            assign tok_prev = 1'b0;
        end
        else
        begin : g_body
            assign tok_prev = live_stat[g-1].tok;
        end

        fbpa_live_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (live_ctl),
            .slot_id   (COUNT_W'(g)),
            .key       (key_reg),
            .new_addr  (append_addr),
            .next_data (nbr_data),
            .tok_in    (tok_prev),
            .data      (live_data[g]),
            .stat      (live_stat[g])
        );

        assign hit_vec[g]  = live_stat[g].hit;
        assign stop_vec[g] = live_stat[g].stop;
    end

    assign hit_any  = |hit_vec;
    // token hit an unused slot, or sits in the last slot without a match
    assign miss_any = (|stop_vec) || (live_stat[LAST].tok && !live_stat[LAST].hit);

    // ------------------------------------------------------------------
    // Free stack: top of stack in slot 0
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_stack
        logic [31:0] up_data;
        logic [31:0] down_data;

        if (g == 0)
        begin : g_top
            assign up_data = key_reg;
        end
        else
        begin : g_deep
            assign up_data = stack_data[g-1];
        end

        if (g == LAST)
        begin : g_bottom
            assign down_data = '0;
        end
        else
        begin : g_inner
            assign down_data = stack_data[g+1];
        end

        fbpa_stack_cell u_cell (
            .clk       (clk),
            .ctl       (stack_ctl),
            .prev_data (up_data),
            .next_data (down_data),
            .data      (stack_data[g])
        );
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = req.kind ? S_SEARCH : S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (out_free && (hit_any || miss_any))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: cell controls, counts, result word
    // ------------------------------------------------------------------
    always_comb
    begin
        live_ctl.start      = 1'b0;
        live_ctl.step       = 1'b0;
        live_ctl.append     = 1'b0;
        live_ctl.remove     = 1'b0;
        live_ctl.live_count = live_count_reg;
        stack_ctl.push      = 1'b0;
        stack_ctl.pop       = 1'b0;
        append_addr         = '0;
        rsp_load            = 1'b0;
        rsp_addr_next       = '0;
        rsp_status_next     = ST_OK;
        free_count_next     = free_count_reg;
        bump_next           = bump_reg;
        live_count_next     = live_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                live_ctl.start = req_accept && req.kind;
            end
            S_ALLOC:
            begin
                if (out_free)
                begin
                    rsp_load = 1'b1;
                    if (size_reg != block_size_reg)
                    begin
                        rsp_status_next = ST_SIZE;
                    end
                    else if (live_full)
                    begin
                        rsp_status_next = ST_OOM;
                    end
                    else if (!stack_empty)
                    begin
                        // reuse the most recently freed block
                        stack_ctl.pop   = 1'b1;
                        free_count_next = free_count_reg - 1'b1;
                        append_addr     = stack_data[0];
                        live_ctl.append = 1'b1;
                        live_count_next = live_count_reg + 1'b1;
                        rsp_addr_next   = stack_data[0];
                    end
                    else if (bump_ok)
                    begin
                        bump_next       = bump_reg + 1'b1;
                        append_addr     = bump_addr;
                        live_ctl.append = 1'b1;
                        live_count_next = live_count_reg + 1'b1;
                        rsp_addr_next   = bump_addr;
                    end
                    else
                    begin
                        rsp_status_next = ST_OOM;
                    end
                end
            end
            S_SEARCH:
            begin
                if (out_free)
                begin
                    if (hit_any)
                    begin
                        rsp_load = 1'b1;
                        if (stack_full)
                        begin
                            rsp_status_next = ST_NOT_LIVE;
                        end
                        else
                        begin
                            live_ctl.remove = 1'b1;
                            stack_ctl.push  = 1'b1;
                            free_count_next = free_count_reg + 1'b1;
                            live_count_next = live_count_reg - 1'b1;
                        end
                    end
                    else if (miss_any)
                    begin
                        rsp_load        = 1'b1;
                        rsp_status_next = ST_NOT_LIVE;
                    end
                    else
                    begin
                        live_ctl.step = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            bump_reg       <= '0;
            live_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            bump_reg       <= bump_next;
            live_count_reg <= live_count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            size_reg <= req.request_size;
            key_reg  <= req.free_address;
        end
        if (rsp_load)
        begin
            rsp_addr_reg   <= rsp_addr_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

endmodule

>>> sv/fbpa_stack_cell.sv
`timescale 1ns / 1ps

module fbpa_stack_cell (
    input  logic                  clk,
    input  fbpa_pkg::stack_ctl_t  ctl,
    input  logic [31:0]           prev_data,
    input  logic [31:0]           next_data,
    output logic [31:0]           data
);
    import fbpa_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;

    // push moves everything one slot deeper, pop pulls it back up
    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = prev_data;
        end
        else if (ctl.pop)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> sv/fbpa_live_cell.sv
`timescale 1ns / 1ps

module fbpa_live_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbpa_pkg::live_ctl_t           ctl,
    input  logic [fbpa_pkg::COUNT_W-1:0]  slot_id,
    input  logic [31:0]                   key,
    input  logic [31:0]                   new_addr,
    input  logic [31:0]                   next_data,
    input  logic                          tok_in,
    output logic [31:0]                   data,
    output fbpa_pkg::live_stat_t          stat
);
    import fbpa_pkg::*;

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        tok_reg;
    logic        tok_next;
    logic        passed_reg;
    logic        passed_next;
    logic        active;
    logic        first;

    assign active = (slot_id < ctl.live_count);
    assign first  = (slot_id == '0);

    always_comb
    begin
        tok_next    = tok_reg;
        passed_next = passed_reg;
        if (ctl.start)
        begin
            tok_next    = first;
            passed_next = 1'b0;
        end
        else if (ctl.step)
        begin
            tok_next    = tok_in;
            passed_next = passed_reg | tok_reg;
        end
    end

    // remove: cells at or past the hit pull the word from the next slot
    always_comb
    begin
        data_next = data_reg;
        if (ctl.append && (slot_id == ctl.live_count))
        begin
            data_next = new_addr;
        end
        else if (ctl.remove && !passed_reg)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            passed_reg <= passed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign stat.tok  = tok_reg;
    assign stat.hit  = tok_reg & active & (data_reg == key);
    assign stat.stop = tok_reg & ~active;

endmodule

>>> sv/fbpa_checker.sv
`timescale 1ns / 1ps

`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_block_address,
    input logic [1:0]  rsp_status
);
    import fbpa_pkg::*;

    // one request in flight: busy right after an accept
    `FBPA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // a failed request never grants an address
    `FBPA_ASSERT_IMPL(a_fail_no_addr, rsp_valid && (rsp_status != ST_OK), rsp_block_address == 32'd0)

    // a new result word only comes out of a busy cycle
    `FBPA_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready))

    // stalled result word holds
    `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_address) && $stable(rsp_status))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_block_address (rsp.block_address),
    .rsp_status        (rsp.status)
);

>>> tb/sv/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    // idle margin after the last answer, before touching config
    localparam int   DRAIN_CYCLES = MAX_BLOCKS + 8;
    // watchdog limit; ~1900 items
    localparam int   CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_size;
        logic [31:0] free_address;
    } req_word_t;

    typedef struct packed {
        logic [31:0] block_address;
        status_t     status;
    } answer_t;

    logic clk;
    logic rst_n;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();
    fbpa_cfg_if cfg_ch ();

    fixed_block_pool_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ---------------------------------------------------------------
    // Shadow of the allocator: config copy plus pool bookkeeping.
    // freed_stack is LIFO (back = top); live_addrs keeps grant order,
    // oldest entry at the front.
    // ---------------------------------------------------------------
    logic [31:0] base_cfg;
    logic [15:0] size_cfg;
    logic [6:0]  count_cfg;
    logic [31:0] freed_stack[$];
    logic [31:0] live_addrs[$];
    int unsigned bump_next;

    req_word_t request_backlog[$];  // words waiting for the driver
    answer_t   due_answers[$];      // predicted answers, oldest first
    req_word_t on_wire;             // word currently driven on req
    int        gap_left;
    int        stall_left;
    int        fault_count;
    int        cycle_count;
    bit        steady;              // set for the final stretch: no idling

    // Answer for one accepted request word; updates the shadow state.
    function automatic answer_t allocator_answer(req_word_t w);
        answer_t     ans;
        int unsigned usable;
        logic [31:0] offset;
        int          i;
        bit          found;
        ans.block_address = 32'd0;
        ans.status        = ST_OK;
        found             = 1'b0;
        if (w.kind == KIND_ALLOC)
        begin
            usable = (count_cfg > MAX_BLOCKS) ? MAX_BLOCKS : count_cfg;
            if (w.request_size != size_cfg)
                ans.status = ST_SIZE;
            else if (live_addrs.size() >= MAX_BLOCKS)
                ans.status = ST_OOM;
            else if (freed_stack.size() != 0)
            begin
                ans.block_address = freed_stack[$];
                freed_stack.delete(freed_stack.size() - 1);
            end
            else if (bump_next >= usable)
                ans.status = ST_OOM;
            else
            begin
                // wraps modulo 2^32
                offset            = bump_next * size_cfg;
                ans.block_address = base_cfg + offset;
                bump_next++;
            end
            if (ans.status == ST_OK)
                live_addrs = {live_addrs, ans.block_address};
        end
        else
        begin
            // oldest match wins; order of the rest is kept
            for (i = 0; i < live_addrs.size() && !found; i++)
            begin
                if (live_addrs[i] == w.free_address)
                begin
                    live_addrs.delete(i);
                    freed_stack = {freed_stack, w.free_address};
                    found = 1'b1;
                end
            end
            if (!found)
                ans.status = ST_NOT_LIVE;
        end
        return ans;
    endfunction

    task automatic flag_fault(string msg);
        fault_count++;
        $display("[%0t] ERROR %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Clock and cycle watchdog
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Request driver: pops the backlog, holds a word until taken,
    // inserts random idle bursts between words.
    // The answer is predicted on the edge the word is accepted.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.kind         <= KIND_ALLOC;
            req_ch.request_size <= 16'd0;
            req_ch.free_address <= 32'd0;
            gap_left            <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                due_answers = {due_answers, allocator_answer(on_wire)};
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0 && !steady
                         && $urandom_range(0, 5) == 0)
                begin
                    gap_left     <= $urandom_range(0, 6);
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    on_wire              = request_backlog.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.kind         <= on_wire.kind;
                    req_ch.request_size <= on_wire.request_size;
                    req_ch.free_address <= on_wire.free_address;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: random backpressure bursts, field-by-field check
    // against the oldest predicted answer.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_answers.size() == 0)
                    flag_fault($sformatf("unexpected result addr=%h status=%0d",
                                         rsp_ch.block_address, rsp_ch.status));
                else
                begin
                    want = due_answers.pop_front();
                    if (rsp_ch.block_address !== want.block_address)
                        flag_fault($sformatf("block_address got %h want %h",
                                             rsp_ch.block_address, want.block_address));
                    if (rsp_ch.status !== want.status)
                        flag_fault($sformatf("status got %0d want %0d (%s)",
                                             rsp_ch.status, want.status, want.status.name()));
                end
            end
            if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                stall_left   <= $urandom_range(0, 6);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers (state checks at negedge, after posedge updates)
    // ---------------------------------------------------------------

    // Sender holds off until every word is accepted and answered.
    task automatic settle();
        while (request_backlog.size() != 0 || req_ch.valid || due_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write; only called while the allocator is idle.
    task automatic program_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_POOL_BASE:   base_cfg  = val;
            CFG_BLOCK_SIZE:  size_cfg  = val[15:0];
            CFG_BLOCK_COUNT: count_cfg = val[6:0];
            default:         ;
        endcase
    endtask

    task automatic set_pool(logic [31:0] base, logic [15:0] bsize, logic [6:0] bcount);
        program_reg(CFG_POOL_BASE, base);
        program_reg(CFG_BLOCK_SIZE, {16'd0, bsize});
        program_reg(CFG_BLOCK_COUNT, {25'd0, bcount});
    endtask

    // Backlog kept short so frees can target addresses live right now.
    task automatic queue_word(logic kind, logic [15:0] rsize, logic [31:0] faddr);
        req_word_t w;
        w.kind         = kind;
        w.request_size = rsize;
        w.free_address = faddr;
        while (request_backlog.size() >= 2)
            @(negedge clk);
        request_backlog = {request_backlog, w};
    endtask

    // Mostly well-formed traffic: right-sized allocs, frees of live blocks.
    // Noise: wrong sizes, double frees, wild addresses.
    task automatic pool_traffic(int n, int alloc_pct);
        int          k;
        int          pick;
        logic [15:0] rsize;
        logic [31:0] faddr;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
            begin
                rsize = size_cfg;
                if ($urandom_range(0, 19) == 0)
                    rsize = 16'($urandom);
                queue_word(KIND_ALLOC, rsize, $urandom);
            end
            else if (pick < 95)
            begin
                if (live_addrs.size() != 0 && $urandom_range(0, 9) != 0)
                    faddr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                else if (freed_stack.size() != 0 && $urandom_range(0, 1) == 0)
                    faddr = freed_stack[$urandom_range(0, freed_stack.size() - 1)];
                else
                    faddr = $urandom;
                queue_word(KIND_FREE, 16'($urandom), faddr);
            end
            else
                queue_word(KIND_ALLOC, 16'($urandom), $urandom);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.request_size = 16'd0;
        req_ch.free_address = 32'd0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_POOL_BASE;
        cfg_ch.wdata        = 32'd0;
        fault_count         = 0;
        cycle_count         = 0;
        steady              = 1'b0;
        base_cfg            = POOL_BASE_RST;
        size_cfg            = BLOCK_SIZE_RST;
        count_cfg           = BLOCK_COUNT_RST;
        bump_next           = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: base 0, 64-byte blocks, 64 blocks
        queue_word(KIND_ALLOC, 16'd64, 32'd0);          // bump -> 0
        queue_word(KIND_ALLOC, 16'd64, 32'd0);          // bump -> 64
        queue_word(KIND_ALLOC, 16'd63, 32'd0);          // size mismatch
        queue_word(KIND_ALLOC, 16'd0, 32'd0);           // size mismatch
        queue_word(KIND_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);  // size mismatch, addr ignored
        queue_word(KIND_FREE, 16'hFFFF, 32'd64);        // size ignored on free
        queue_word(KIND_FREE, 16'd0, 32'd64);           // double free: not live
        queue_word(KIND_ALLOC, 16'd64, 32'd0);          // reuses 64 from the stack
        queue_word(KIND_FREE, 16'd0, 32'hFFFF_FFFF);    // never granted
        queue_word(KIND_FREE, 16'd0, 32'd0);            // oldest live entry
        queue_word(KIND_FREE, 16'd0, 32'd64);
        settle();

        // zero blocks: only the free stack can serve, then out of memory
        program_reg(CFG_BLOCK_COUNT, 32'd0);
        queue_word(KIND_ALLOC, 16'd64, 32'd0);
        queue_word(KIND_ALLOC, 16'd64, 32'd0);
        queue_word(KIND_ALLOC, 16'd64, 32'd0);
        settle();

        // bump address wraps past 2^32 with the largest block size
        set_pool(32'hFFFF_0000, 16'hFFFF, 7'd64);
        queue_word(KIND_ALLOC, 16'hFFFF, 32'd0);
        queue_word(KIND_ALLOC, 16'd64, 32'd0);          // old size now wrong
        queue_word(KIND_FREE, 16'd0, 32'h0000_FFFE);
        queue_word(KIND_ALLOC, 16'hFFFF, 32'd0);        // back from the stack
        settle();

        // rebase so the next bump grant duplicates live address 0;
        // frees then take the oldest copy first
        program_reg(CFG_BLOCK_SIZE, 32'd1);
        program_reg(CFG_POOL_BASE, 32'd0 - bump_next);
        queue_word(KIND_ALLOC, 16'd1, 32'd0);
        queue_word(KIND_FREE, 16'd0, 32'd0);
        queue_word(KIND_FREE, 16'd0, 32'd0);
        queue_word(KIND_FREE, 16'd0, 32'd0);
        settle();

        // small pool: bump runs out early, then reuse churn
        set_pool($urandom, 16'($urandom_range(1, 300)), 7'd20);
        pool_traffic(200, 75);
        pool_traffic(150, 35);
        settle();

        // full pool at the top of the address space: fill to out of memory
        set_pool(32'hFFFF_FFFF, 16'hFFFF, 7'd64);
        pool_traffic(250, 80);
        pool_traffic(200, 30);

        // sender pauses mid-phase until every answer is back
        settle();
        set_pool($urandom, 16'($urandom), 7'($urandom_range(0, 64)));
        pool_traffic(250, 60);
        settle();
        pool_traffic(250, 45);
        settle();

        set_pool(32'd0, 16'd1, 7'd64);
        pool_traffic(300, 55);
        // final stretch with no idling on either side
        steady = 1'b1;
        pool_traffic(300, 50);
        settle();

        if (due_answers.size() != 0)
            flag_fault($sformatf("%0d answers never arrived", due_answers.size()));
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_if.sv
sv/fbpa_stack_cell.sv
sv/fbpa_live_cell.sv
sv/fixed_block_pool_allocator.sv
sv/fbpa_checker.sv
tb/sv/fixed_block_pool_allocator_tb.sv
